FILE: sv/text_console_character_writer_assert.svh
// ============================================================================
// Assertion macros for the text console character writer
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_ASSERT_SVH

`ifndef ASSERT_OFF
`define TCW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcw check failed");
`define TCW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcw check failed");
`else
`define TCW_ASSERT_IMP(label, ante, cons)
`define TCW_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: sv/tcw_pkg.sv
// ============================================================================
// tcw_pkg
// Geometry, codes, types and helpers shared by the console writer modules.
// ============================================================================
`default_nettype none

package tcw_pkg;

    // COLUMNS and ROWS are powers of two: a cell address is {row, column}
    localparam int COLUMNS   = 32;
    localparam int ROWS      = 32;
    localparam int CELLS     = ROWS * COLUMNS;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CUR_COL_W = 6;
    localparam int IDX_W     = 10;
    localparam int FUNC_W    = 2;
    localparam int CODE_W    = 8;

    localparam int TCW_QUEUE_DEPTH = 4;

    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CODE_W-1:0] CODE_BS = 8'd8;
    localparam logic [CODE_W-1:0] CODE_LF = 8'd10;
    localparam logic [CODE_W-1:0] CODE_CR = 8'd13;

    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [COL_W-1:0]     col_t;
    typedef logic [CUR_COL_W-1:0] cur_col_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [CODE_W-1:0]    char_t;

    typedef struct packed {
        logic     clear_all;
        logic     inv0_en;
        row_t     inv0_row;
        logic     inv1_en;
        row_t     inv1_row;
        logic     wr_en;
        logic     rd_en;
        row_t     acc_row;
        col_t     acc_col;
        char_t    wr_data;
        cur_col_t cur_col;
        row_t     cur_row;
    } cmd_t;

    typedef struct packed {
        cur_col_t cursor_column;
        row_t     cursor_line;
        char_t    read_data;
    } res_t;

    function automatic row_t phys_row(row_t r, row_t b);
        logic [ROW_W:0] s;
        s = {1'b0, r} + {1'b0, b};
        if (s >= (ROW_W + 1)'(ROWS))
        begin
            s = s - (ROW_W + 1)'(ROWS);
        end
        return s[ROW_W-1:0];
    endfunction

    function automatic row_t next_row(row_t r);
        row_t n;
        if (r == ROW_W'(ROWS - 1))
        begin
            n = '0;
        end
        else
        begin
            n = r + 1'b1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: sv/text_console_character_writer.sv
// ============================================================================
// text_console_character_writer
// Character store of ROWS x COLUMNS cells with cursor, wrap and scroll.
// ============================================================================
// Each transfer in returns exactly one transfer out: the cursor after the
// operation and, for a read, the cell. A front end decodes transfers at up to
// one per cycle into a command queue; the back end owns the store. Rows form
// a ring with a base offset and a live bit per row, so scroll, line feed and
// clear need no pass over the store. In the back end an item goes from idle to
// the result state, except the first write of a non-zero code into a row that
// was cleared since it was last filled: that write first zeroes the whole row
// in a sweep state.
// Read data comes from a registered port of the single-port store.
`default_nettype none

module text_console_character_writer
    import tcw_pkg::*;
#(
    parameter int QUEUE_DEPTH = TCW_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // code[7:0], cell_index[17:8], zero pad
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // cursor_column[5:0], cursor_line[10:6],
                                        // read_data[18:11], zero pad
);

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;
    res_t res;

    tcw_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .func       (s_tuser),
        .code       (s_tdata[7:0]),
        .cell_index (s_tdata[17:8]),
        .queue_full (full),
        .push       (push),
        .cmd        (front_cmd)
    );

    tcw_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (front_cmd),
        .pop    (pop),
        .rd_cmd (head_cmd),
        .full   (full),
        .empty  (empty)
    );

    tcw_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_valid (!empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res)
    );

    assign m_tdata = {5'b0, res.read_data, res.cursor_line, res.cursor_column};

`include "text_console_character_writer_assert.svh"

    `TCW_ASSERT_IMP(a_pop_nonempty, pop, !empty)
    `TCW_ASSERT_IMP(a_push_not_full, push, !full)
    `TCW_ASSERT_NXT(a_push_fills, push && !pop, !empty)
    `TCW_ASSERT_IMP(a_cursor_range, m_tvalid, res.cursor_column <= CUR_COL_W'(COLUMNS))

endmodule

`default_nettype wire

FILE: sv/tcw_front.sv
// ============================================================================
// tcw_front
// Decodes each transfer, tracks the cursor and ring base, emits a command.
// ============================================================================
`default_nettype none

module tcw_front
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [FUNC_W-1:0] func,
    input  wire char_t             code,
    input  wire logic [IDX_W-1:0]  cell_index,
    input  wire logic              queue_full,
    output logic                   push,
    output cmd_t                   cmd
);

    cur_col_t col_reg, col_next;
    row_t     row_reg, row_next;
    row_t     base_reg, base_next;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        cur_col_t c;
        row_t     r;
        row_t     b;
        c   = col_reg;
        r   = row_reg;
        b   = base_reg;
        cmd = '0;
        unique case (func)
            FUNC_PUT:
            begin
                if (c >= CUR_COL_W'(COLUMNS))
                begin
                    c = '0;
                    if (r == ROW_W'(ROWS - 1))
                    begin
                        b = next_row(b);
                    end
                    else
                    begin
                        r = r + 1'b1;
                    end
                    cmd.inv0_en  = 1'b1;
                    cmd.inv0_row = phys_row(r, b);
                end
                cmd.acc_row = phys_row(r, b);
                cmd.acc_col = c[COL_W-1:0];
                unique case (code)
                    CODE_BS:
                    begin
                        if (c != '0)
                        begin
                            c            = c - 1'b1;
                            cmd.acc_col  = c[COL_W-1:0];
                            cmd.wr_en    = 1'b1;
                            cmd.wr_data  = '0;
                        end
                    end
                    CODE_LF:
                    begin
                        if (r == ROW_W'(ROWS - 1))
                        begin
                            b = next_row(b);
                        end
                        else
                        begin
                            r = r + 1'b1;
                        end
                        cmd.inv1_en  = 1'b1;
                        cmd.inv1_row = phys_row(r, b);
                    end
                    CODE_CR:
                    begin
                        c = '0;
                    end
                    default:
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_data = code;
                        c           = c + 1'b1;
                    end
                endcase
            end
            FUNC_READ:
            begin
                cmd.rd_en   = ({1'b0, cell_index} < (IDX_W + 1)'(CELLS));
                cmd.acc_row = phys_row(cell_index[COL_W +: ROW_W], b);
                cmd.acc_col = cell_index[COL_W-1:0];
            end
            FUNC_CLEAR:
            begin
                cmd.clear_all = 1'b1;
            end
            default:
            begin
                cmd.clear_all = 1'b0;
            end
        endcase
        cmd.cur_col = c;
        cmd.cur_row = r;
        col_next    = push ? c : col_reg;
        row_next    = push ? r : row_reg;
        base_next   = push ? b : base_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tcw_cmd_fifo.sv
// ============================================================================
// tcw_cmd_fifo
// Short command queue between the decode front and the store back end.
// ============================================================================
`default_nettype none

module tcw_cmd_fifo
    import tcw_pkg::*;
#(
    parameter int DEPTH = TCW_QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t wr_cmd,
    input  wire logic pop,
    output cmd_t      rd_cmd,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tcw_back.sv
// ============================================================================
// tcw_back
// Executes commands on the character store and drives the result register.
// ============================================================================
`default_nettype none

module tcw_back
    import tcw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t head,
    input  wire logic head_valid,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [ROWS-1:0] row_valid_reg, row_valid_next;
    col_t            sweep_col_reg, sweep_col_next;
    cmd_t            cmd_reg, cmd_next;
    logic            rd_hit_reg, rd_hit_next;
    logic            out_valid_reg, out_valid_next;
    res_t            out_res_reg, out_res_next;
    char_t           rd_data_reg;
    char_t           mem [CELLS];

    logic            mem_we;
    addr_t           mem_waddr;
    char_t           mem_wdata;
    logic            mem_re;
    addr_t           mem_raddr;
    logic [ROWS-1:0] valid_eff;
    logic            out_load;

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        valid_eff = row_valid_reg;
        if (head.clear_all)
        begin
            valid_eff = '0;
        end
        if (head.inv0_en)
        begin
            valid_eff[head.inv0_row] = 1'b0;
        end
        if (head.inv1_en)
        begin
            valid_eff[head.inv1_row] = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        row_valid_next = row_valid_reg;
        sweep_col_next = sweep_col_reg;
        cmd_next       = cmd_reg;
        rd_hit_next    = rd_hit_reg;
        out_res_next   = out_res_reg;
        pop            = 1'b0;
        out_load       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = {head.acc_row, head.acc_col};
        mem_wdata      = head.wr_data;
        mem_re         = 1'b0;
        mem_raddr      = {head.acc_row, head.acc_col};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop            = 1'b1;
                    cmd_next       = head;
                    row_valid_next = valid_eff;
                    rd_hit_next    = head.rd_en && valid_eff[head.acc_row];
                    mem_re         = head.rd_en;
                    if (head.wr_en && !valid_eff[head.acc_row] && (head.wr_data != '0))
                    begin
                        sweep_col_next = '0;
                        state_next     = ST_SWEEP;
                    end
                    else
                    begin
                        mem_we     = head.wr_en && valid_eff[head.acc_row];
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = {cmd_reg.acc_row, sweep_col_reg};
                mem_wdata = (sweep_col_reg == cmd_reg.acc_col) ? cmd_reg.wr_data : '0;
                sweep_col_next = sweep_col_reg + 1'b1;
                if (sweep_col_reg == COL_W'(COLUMNS - 1))
                begin
                    row_valid_next[cmd_reg.acc_row] = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load                   = 1'b1;
                    out_res_next.cursor_column = cmd_reg.cur_col;
                    out_res_next.cursor_line   = cmd_reg.cur_row;
                    out_res_next.read_data     = rd_hit_reg ? rd_data_reg : '0;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        rd_hit_reg    <= rd_hit_next;
        out_res_reg   <= out_res_next;
        sweep_col_reg <= sweep_col_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ============================================================================
// Testbench for text_console_character_writer
// Drives put, read, clear and unused operations as stream transfers with
// random gaps on both sides. A scoreboard class predicts the cursor and the
// cell contents and compares every result transfer, field by field, in order.
// ============================================================================
`default_nettype none

module testbench;
    import tcw_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int STIM_ITEMS  = 1400;
    localparam int CYCLE_LIMIT = 800000;
    localparam int TAIL_CYCLES = 80;
    localparam int PRINT_CAP   = 100;

    typedef struct {
        cur_col_t col;
        row_t     line;
        char_t    data;
    } cursor_result_t;

    class console_scoreboard;
        char_t          cells [CELLS];
        int             col;
        int             row;
        cursor_result_t awaited_results [$];
        int             errors;

        function new();
            foreach (cells[i])
                cells[i] = '0;
            col    = 0;
            row    = 0;
            errors = 0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        task report(string what, int got, int want);
            errors++;
            if (errors <= PRINT_CAP)
                $display("mismatch: %s got %0d want %0d", what, got, want);
        endtask

        function void wipe_line(int r);
            if (r < ROWS)
                for (int c = 0; c < COLUMNS; c++)
                    cells[r * COLUMNS + c] = '0;
        endfunction

        function void scroll_store();
            for (int i = 0; i < CELLS - COLUMNS; i++)
                cells[i] = cells[i + COLUMNS];
        endfunction

        function void apply_put(char_t code);
            if (col >= COLUMNS)
            begin
                col = 0;
                row++;
                wipe_line(row);
            end
            if (row >= ROWS)
            begin
                scroll_store();
                row = ROWS - 1;
                wipe_line(row);
            end
            if (code == CODE_BS)
            begin
                if (col > 0)
                begin
                    col--;
                    cells[row * COLUMNS + col] = '0;
                end
            end
            else if (code == CODE_LF)
            begin
                row++;
                if (row >= ROWS)
                begin
                    scroll_store();
                    row = ROWS - 1;
                end
                wipe_line(row);
            end
            else if (code == CODE_CR)
            begin
                col = 0;
            end
            else
            begin
                cells[row * COLUMNS + col] = code;
                col++;
            end
        endfunction

        function void note_transfer_in(logic [FUNC_W-1:0] func, char_t code,
                                       logic [IDX_W-1:0] idx);
            cursor_result_t e;
            char_t          data;
            data = '0;
            case (func)
                FUNC_PUT:   apply_put(code);
                FUNC_READ:  if (idx < CELLS) data = cells[idx];
                FUNC_CLEAR: foreach (cells[i]) cells[i] = '0;
                default:    ;
            endcase
            e.col  = cur_col_t'(col);
            e.line = row_t'(row);
            e.data = data;
            awaited_results.push_back(e);
        endfunction

        task check_transfer_out(logic [23:0] tdata);
            cursor_result_t e;
            if (awaited_results.size() == 0)
            begin
                report("result with nothing awaited, tdata", tdata, 0);
            end
            else
            begin
                e = awaited_results.pop_front();
                if (tdata[5:0] !== e.col)
                    report("cursor_column", tdata[5:0], e.col);
                if (tdata[10:6] !== e.line)
                    report("cursor_line", tdata[10:6], e.line);
                if (tdata[18:11] !== e.data)
                    report("read_data", tdata[18:11], e.data);
            end
        endtask

        task flush_leftover();
            while (awaited_results.size() != 0)
            begin
                report("result never arrived, awaited", awaited_results.size(), 0);
                void'(awaited_results.pop_front());
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    console_scoreboard sb;
    int  sent;
    int  cycles;
    bit  calm_tx;
    bit  calm_rx;

    text_console_character_writer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int draw_gap(bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic char_t text_code();
        if ($urandom_range(0, 9) == 0)
            return char_t'($urandom_range(0, 255));
        return char_t'($urandom_range(32, 126));
    endfunction

    // hold the transfer until accepted, then note it
    task send(logic [FUNC_W-1:0] func, char_t code, logic [IDX_W-1:0] idx);
        int gap;
        gap = draw_gap(calm_tx);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'd0, idx, code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_transfer_in(func, code, idx);
        sent++;
    endtask

    task put_code(char_t code);
        send(FUNC_PUT, code, IDX_W'($urandom_range(0, 1023)));
    endtask

    task read_cell(int idx);
        send(FUNC_READ, char_t'($urandom_range(0, 255)), IDX_W'(idx));
    endtask

    task read_near_cursor();
        read_cell(sb.row * COLUMNS + $urandom_range(0, COLUMNS - 1));
    endtask

    // hold off until every awaited result has been taken
    task drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task random_item();
        send(FUNC_W'($urandom_range(0, 3)), char_t'($urandom_range(0, 255)),
             IDX_W'($urandom_range(0, 1023)));
    endtask

    task directed_part();
        read_cell(0);
        read_cell(CELLS - 1);
        put_code(CODE_BS);
        put_code(8'hFF);
        put_code(8'h00);
        put_code(8'h41);
        read_cell(0);
        read_cell(1);
        read_cell(2);
        put_code(CODE_BS);
        read_cell(2);
        put_code(CODE_CR);
        put_code(CODE_LF);
        read_cell(0);
        send(FUNC_NONE, 8'hFF, 10'h3FF);
        put_code(8'h7E);
        send(FUNC_CLEAR, 8'h00, 10'h000);
        read_cell(COLUMNS);
        read_cell(0);
        put_code(CODE_LF);
        put_code(CODE_BS);
        read_cell(CELLS - 1);
    endtask

    task random_part();
        int kind;
        int n;
        while (sent < STIM_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
                calm_tx = ~calm_tx;
            if ($urandom_range(0, 40) == 0)
                drain();
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3:
                begin
                    n = $urandom_range(1, 40);
                    repeat (n) put_code(text_code());
                    read_near_cursor();
                    if ($urandom_range(0, 1) == 0)
                    begin
                        put_code(CODE_CR);
                        put_code(CODE_LF);
                    end
                end
                4:
                begin
                    n = (sb.col >= COLUMNS) ? 0 : COLUMNS - sb.col;
                    repeat (n) put_code(text_code());
                    read_near_cursor();
                    case ($urandom_range(0, 4))
                        0: put_code(CODE_BS);
                        1: put_code(CODE_LF);
                        2: put_code(CODE_CR);
                        3: put_code(text_code());
                        default: send(FUNC_CLEAR, char_t'($urandom_range(0, 255)),
                                      IDX_W'($urandom_range(0, 1023)));
                    endcase
                    read_near_cursor();
                end
                5:
                begin
                    n = $urandom_range(1, 36);
                    repeat (n)
                    begin
                        put_code(CODE_LF);
                        put_code(text_code());
                    end
                    repeat (4) read_cell($urandom_range(0, CELLS - 1));
                end
                6:
                begin
                    n = $urandom_range(1, 8);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            read_near_cursor();
                        else
                            read_cell($urandom_range(0, 1023));
                    end
                end
                7:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                    begin
                        put_code(CODE_BS);
                        if ($urandom_range(0, 2) == 0)
                            put_code(text_code());
                    end
                    read_near_cursor();
                end
                8:
                begin
                    random_item();
                end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        send(FUNC_CLEAR, char_t'($urandom_range(0, 255)),
                             IDX_W'($urandom_range(0, 1023)));
                    else
                        put_code(CODE_CR);
                end
            endcase
        end
    endtask

    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                calm_rx = ~calm_rx;
            gap = draw_gap(calm_rx);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check_transfer_out(m_tdata);
        end
    end

    initial
    begin
        sb       = new();
        sent     = 0;
        calm_tx  = 1'b0;
        calm_rx  = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_part();
        drain();
        random_part();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.flush_leftover();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
